### rtl/greedy_geographic_next_hop_macros.svh
// Assertion helpers used by the checker file.
`ifndef GREEDY_GEOGRAPHIC_NEXT_HOP_MACROS_SVH
`define GREEDY_GEOGRAPHIC_NEXT_HOP_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define GGNH_ASSERT_IMP(lbl, ck, rs, a, c, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (c)) else $error(msg);

// Next-cycle implication, off while reset is high.
`define GGNH_ASSERT_NXT(lbl, ck, rs, a, c, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) else $error(msg);

`endif

### rtl/ggnh_pkg.sv
package ggnh_pkg;

  // Running count carried by a pass; covers tables of up to 256 entries.
  localparam int COUNT_W = 9;

  typedef enum logic [1:0] {
    OP_BEACON = 2'd0,
    OP_PURGE  = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_FAR  = 2'd2
  } status_t;

  // What a pass down the cell row does.
  typedef enum logic [2:0] {
    PASS_MATCH,   // refresh an entry with the same address
    PASS_INSERT,  // claim the first free entry
    PASS_PURGE,
    PASS_LOOKUP,
    PASS_NOP
  } pass_t;

  typedef struct packed {
    logic                live;
    pass_t               kind;
    logic [31:0]         addr;
    logic signed [15:0]  px;
    logic signed [15:0]  py;
    logic [31:0]         now;
    logic                hit;       // matched / placed / have a closer hop
    logic [32:0]         best;      // best squared distance so far
    logic [31:0]         best_addr;
    logic [COUNT_W-1:0]  count;     // valid entries seen so far
  } token_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SELF,
    S_LAUNCH,
    S_RUN,
    S_HOLD
  } state_t;

endpackage

### rtl/ggnh_cell.sv
module ggnh_cell import ggnh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] interval,
  input  token_t      tok_in,
  output token_t      tok_out
);

  logic               valid;
  logic               valid_next;
  logic [31:0]        e_addr;
  logic signed [15:0] e_x;
  logic signed [15:0] e_y;
  logic [31:0]        e_time;

  token_t             mid;
  token_t             mid_next;
  token_t             tok_next;
  logic [31:0]        dxx;
  logic [31:0]        dyy;

  logic               match;
  logic               expired;
  logic               write_en;
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic signed [33:0] sq_x;
  logic signed [33:0] sq_y;
  logic [32:0]        span;
  logic               better;

  // Stage 1: entry update and distance products.
  assign match    = valid && (e_addr == tok_in.addr);
  assign expired  = valid &&
                    (({1'b0, e_time} + {17'b0, interval}) <= {1'b0, tok_in.now});
  assign write_en = tok_in.live &&
                    (((tok_in.kind == PASS_MATCH) && match) ||
                     ((tok_in.kind == PASS_INSERT) && !valid && !tok_in.hit));

  assign dx   = {tok_in.px[15], tok_in.px} - {e_x[15], e_x};
  assign dy   = {tok_in.py[15], tok_in.py} - {e_y[15], e_y};
  assign sq_x = dx * dx;
  assign sq_y = dy * dy;

  always_comb begin
    valid_next = valid;
    if (write_en) begin
      valid_next = 1'b1;
    end else if (tok_in.live && (tok_in.kind == PASS_PURGE) && expired) begin
      valid_next = 1'b0;
    end
    mid_next = tok_in;
    if (write_en) begin
      mid_next.hit = 1'b1;
    end
    mid_next.count = tok_in.count + {{(COUNT_W-1){1'b0}}, valid_next};
  end

  // Stage 2: closest-neighbor compare, lower address wins a tie.
  assign span   = {1'b0, dxx} + {1'b0, dyy};
  assign better = (mid.kind == PASS_LOOKUP) && valid &&
                  ((span < mid.best) ||
                   (mid.hit && (span == mid.best) && (e_addr < mid.best_addr)));

  always_comb begin
    tok_next = mid;
    if (better) begin
      tok_next.best      = span;
      tok_next.best_addr = e_addr;
      tok_next.hit       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= 1'b0;
      mid.live     <= 1'b0;
      tok_out.live <= 1'b0;
    end else begin
      valid   <= valid_next;
      mid     <= mid_next;
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    dxx <= sq_x[31:0];
    dyy <= sq_y[31:0];
    if (write_en) begin
      e_addr <= tok_in.addr;
      e_x    <= tok_in.px;
      e_y    <= tok_in.py;
      e_time <= tok_in.now;
    end
  end

endmodule

### rtl/greedy_geographic_next_hop.sv
// Greedy geographic next hop: neighbor table with beacon, purge and lookup.
//
// Input channel s_axis_*: one item per operation, opcode in tuser. Output
// channel m_axis_*: one result item per input item, status in tuser.
// cfg_*: write of the validity interval, always ready, meant for idle time.
//
// Each table entry lives in its own cell; an operation travels down the
// row of NEIGHBORS cells as a token, and each cell registers it after the
// entry update and the distance products and again after the compare. A
// beacon for an address not yet in the table makes a second pass to claim
// the first free cell. One item is in work at a time; the next is taken
// once the result sits in the output register.
// Reset empties the table and sets the interval to 4500 ticks.
// If the receiver stalls, the result waits in the output register and the
// block holds the next finished result until that register frees up.
module greedy_geographic_next_hop import ggnh_pkg::*; #(
  parameter int NEIGHBORS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // node_address[31:0], pos_x[47:32], pos_y[63:48], self_x[79:64],
  // self_y[95:80], now[127:96]
  input  logic [127:0] s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // next_hop[31:0], neighbor_count[37:32], zero pad [39:38]
  output logic [39:0]  m_axis_tdata,
  // status[1:0]
  output logic [1:0]   m_axis_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data
);

  state_t state;
  state_t state_next;

  logic [15:0]        interval;
  token_t             job;       // operation being worked on
  logic signed [15:0] sx;
  logic signed [15:0] sy;
  logic [31:0]        sxx;
  logic [31:0]        syy;
  token_t             head;
  token_t             head_next;
  token_t             link [NEIGHBORS+1];
  token_t             tail;

  logic               launch;
  logic               retry;
  logic               load_out;

  logic [1:0]         res_status;
  logic [1:0]         res_status_next;
  logic [31:0]        res_hop;
  logic [31:0]        res_hop_next;
  logic [5:0]         res_count;
  logic [1:0]         out_status;
  logic [31:0]        out_hop;
  logic [5:0]         out_count;

  pass_t              in_kind;
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic signed [33:0] sq_x;
  logic signed [33:0] sq_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= 16'd4500;
    end else if (cfg_valid && cfg_ready) begin
      interval <= cfg_data;
    end
  end

  always_comb begin
    case (op_t'(s_axis_tuser))
      OP_BEACON: in_kind = PASS_MATCH;
      OP_PURGE:  in_kind = PASS_PURGE;
      OP_LOOKUP: in_kind = PASS_LOOKUP;
      default:   in_kind = PASS_NOP;
    endcase
  end

  // Own squared distance to the destination, the bar a neighbor must beat.
  assign dx   = {job.px[15], job.px} - {sx[15], sx};
  assign dy   = {job.py[15], job.py} - {sy[15], sy};
  assign sq_x = dx * dx;
  assign sq_y = dy * dy;

  // Control
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    launch        = 1'b0;
    retry         = 1'b0;
    load_out      = 1'b0;
    case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = S_SELF;
        end
      end
      S_SELF: state_next = S_LAUNCH;
      S_LAUNCH: begin
        launch     = 1'b1;
        state_next = S_RUN;
      end
      S_RUN: begin
        if (tail.live) begin
          if ((tail.kind == PASS_MATCH) && !tail.hit) begin
            retry      = 1'b1;
            state_next = S_LAUNCH;
          end else begin
            state_next = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Job capture, self distance and token launch
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      job.live      <= 1'b1;
      job.kind      <= in_kind;
      job.addr      <= s_axis_tdata[31:0];
      job.px        <= s_axis_tdata[47:32];
      job.py        <= s_axis_tdata[63:48];
      job.now       <= s_axis_tdata[127:96];
      job.hit       <= 1'b0;
      job.best      <= '0;
      job.best_addr <= '0;
      job.count     <= '0;
      sx            <= s_axis_tdata[79:64];
      sy            <= s_axis_tdata[95:80];
    end else if (retry) begin
      job.kind <= PASS_INSERT;
    end
    if (state == S_SELF) begin
      sxx <= sq_x[31:0];
      syy <= sq_y[31:0];
    end
  end

  always_comb begin
    head_next           = job;
    head_next.live      = launch;
    head_next.hit       = 1'b0;
    head_next.best      = {1'b0, sxx} + {1'b0, syy};
    head_next.best_addr = 32'd0;
    head_next.count     = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head.live <= 1'b0;
    end else begin
      head <= head_next;
    end
  end

  // Cell row
  assign link[0] = head;

  for (genvar i = 0; i < NEIGHBORS; i++) begin : g_cell
    ggnh_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .interval (interval),
      .tok_in   (link[i]),
      .tok_out  (link[i+1])
    );
  end

  assign tail = link[NEIGHBORS];

  // Result decode from the token leaving the row
  always_comb begin
    res_status_next = ST_OK;
    res_hop_next    = 32'd0;
    case (tail.kind)
      PASS_INSERT: begin
        if (!tail.hit) begin
          res_status_next = ST_FULL;
        end
      end
      PASS_LOOKUP: begin
        if (tail.hit) begin
          res_hop_next = tail.best_addr;
        end else begin
          res_status_next = ST_FAR;
        end
      end
      default: res_status_next = ST_OK;
    endcase
  end

  // Result capture and output register
  always_ff @(posedge clk) begin
    if ((state == S_RUN) && tail.live) begin
      res_count  <= tail.count[5:0];
      res_hop    <= res_hop_next;
      res_status <= res_status_next;
    end
    if (load_out) begin
      out_status <= res_status;
      out_hop    <= res_hop;
      out_count  <= res_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  assign m_axis_tdata = {2'b00, out_count, out_hop};
  assign m_axis_tuser = out_status;

endmodule

### rtl/ggnh_checker.sv
`include "greedy_geographic_next_hop_macros.svh"

module ggnh_checker import ggnh_pkg::*; #(
  parameter int NEIGHBORS = 32
) (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [39:0]  m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  // One item at a time: the input closes right after an accept.
  `GGNH_ASSERT_NXT(a_one_in_flight, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while an item is in work")

  // A hop address only comes with an ok status.
  `GGNH_ASSERT_IMP(a_hop_zero, clk, rst, m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tdata[31:0] == 32'd0, "next hop set on a failed result")

  // A dropped beacon means every cell is taken.
  `GGNH_ASSERT_IMP(a_full_count, clk, rst, m_axis_tvalid && (m_axis_tuser == ST_FULL), m_axis_tdata[37:32] == 6'(NEIGHBORS), "table full reported with free cells")

  // Stalled result holds.
  `GGNH_ASSERT_NXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed under stall")

endmodule

bind greedy_geographic_next_hop ggnh_checker #(.NEIGHBORS(NEIGHBORS)) u_checker (.*);

### tb/greedy_geographic_next_hop_tb.sv
module greedy_geographic_next_hop_tb;
  import ggnh_pkg::*;

  localparam int NEIGHBORS = 32;
  // Longest single operation: a beacon for a new address makes two passes.
  localparam int OP_CYCLES = 4 * NEIGHBORS + 16;
  // Cycles with no handshake anywhere before the run is declared hung.
  localparam int QUIET_LIMIT = 5000;
  localparam int PHASES = 5;
  localparam int ITEMS_PER_PHASE = 130;

  typedef struct {
    op_t                op;
    logic [31:0]        addr;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic [31:0]        now;
  } hop_req_t;

  typedef struct {
    status_t     status;
    logic [31:0] hop;
    logic [5:0]  count;
  } hop_reply_t;

  typedef struct {
    hop_req_t   req;
    bit         typed;  // reply typed in by hand instead of predicted
    hop_reply_t rep;
  } script_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // node_address[31:0], pos_x[47:32], pos_y[63:48], self_x[79:64],
  // self_y[95:80], now[127:96]
  logic [127:0] s_axis_tdata = '0;
  // opcode[1:0]
  logic [1:0]   s_axis_tuser = OP_NOP;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // next_hop[31:0], neighbor_count[37:32], zero pad [39:38]
  logic [39:0]  m_axis_tdata;
  // status[1:0]
  logic [1:0]   m_axis_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [15:0]  cfg_data = '0;

  greedy_geographic_next_hop #(.NEIGHBORS(NEIGHBORS)) uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow neighbor table, kept in step with every accepted item.
  // ---------------------------------------------------------------------
  bit                 tbl_valid [NEIGHBORS];
  logic [31:0]        tbl_addr  [NEIGHBORS];
  logic signed [15:0] tbl_x     [NEIGHBORS];
  logic signed [15:0] tbl_y     [NEIGHBORS];
  logic [31:0]        tbl_time  [NEIGHBORS];
  logic [15:0]        hold_ticks = 16'd4500;  // validity interval after reset

  hop_reply_t  hop_replies[$];   // replies still owed by the block, oldest first
  script_row_t script[$];
  int          mismatches = 0;
  int          quiet = 0;

  function automatic logic [63:0] sq_span(logic signed [15:0] ax, logic signed [15:0] ay,
                                          logic signed [15:0] bx, logic signed [15:0] by);
    longint dx;
    longint dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    return 64'(dx * dx + dy * dy);
  endfunction

  // Applies one operation to the shadow table and returns the reply it earns.
  function automatic hop_reply_t route_table_apply(hop_req_t r);
    hop_reply_t  o;
    int          slot;
    int          n;
    bit          have;
    logic [63:0] best;
    logic [63:0] d;
    logic [31:0] best_addr;
    o.status = ST_OK;
    o.hop = '0;
    slot = -1;
    n = 0;
    have = 1'b0;
    best_addr = '0;
    case (r.op)
      OP_BEACON: begin
        // refresh wins over insert, even on a full table
        for (int i = 0; i < NEIGHBORS; i++)
          if (slot < 0 && tbl_valid[i] && tbl_addr[i] == r.addr) slot = i;
        for (int i = 0; i < NEIGHBORS; i++)
          if (slot < 0 && !tbl_valid[i]) slot = i;
        if (slot >= 0) begin
          tbl_valid[slot] = 1'b1;
          tbl_addr[slot]  = r.addr;
          tbl_x[slot]     = r.px;
          tbl_y[slot]     = r.py;
          tbl_time[slot]  = r.now;
        end else begin
          o.status = ST_FULL;
        end
      end
      OP_PURGE: begin
        // 33-bit sum: no wrap on stamps near the top of the tick range
        for (int i = 0; i < NEIGHBORS; i++)
          if (tbl_valid[i] && ({1'b0, tbl_time[i]} + {17'b0, hold_ticks} <= {1'b0, r.now}))
            tbl_valid[i] = 1'b0;
      end
      OP_LOOKUP: begin
        best = sq_span(r.px, r.py, r.sx, r.sy);
        for (int i = 0; i < NEIGHBORS; i++) begin
          if (tbl_valid[i]) begin
            d = sq_span(r.px, r.py, tbl_x[i], tbl_y[i]);
            if (d < best || (have && d == best && tbl_addr[i] < best_addr)) begin
              best = d;
              best_addr = tbl_addr[i];
              have = 1'b1;
            end
          end
        end
        if (have) o.hop = best_addr;
        else o.status = ST_FAR;
      end
      default: ;
    endcase
    for (int i = 0; i < NEIGHBORS; i++)
      if (tbl_valid[i]) n++;
    o.count = 6'(n);
    return o;
  endfunction

  // ---------------------------------------------------------------------
  // Result side: random back-pressure and checking.
  // ---------------------------------------------------------------------
  int stall_left = 0;
  int rdy_roll;
  bit calm = 1'b0;  // stretches with the receiver always ready

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if ($urandom_range(0, 299) == 0) calm <= ~calm;
      rdy_roll = $urandom_range(0, 99);
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (calm || rdy_roll < 70) begin
        m_axis_tready <= 1'b1;
      end else begin
        // mostly short stalls, now and then a long one
        m_axis_tready <= 1'b0;
        stall_left <= (rdy_roll < 96) ? $urandom_range(0, 2) : $urandom_range(15, 60);
      end
    end
  end

  always @(posedge clk) begin
    hop_reply_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (hop_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: status %0d hop %h count %0d",
                   m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[37:32]);
      end else begin
        want = hop_replies.pop_front();
        if (m_axis_tuser != want.status || m_axis_tdata[31:0] != want.hop ||
            m_axis_tdata[37:32] != want.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want status %0d hop %h count %0d, got status %0d hop %h count %0d",
                     want.status, want.hop, want.count,
                     m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[37:32]);
        end
      end
    end
  end

  // Watchdog: any handshake restarts the count.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
  end

  initial begin
    wait (quiet >= QUIET_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------
  task automatic send_op(input hop_req_t r, input bit typed, input hop_reply_t fixed);
    hop_reply_t p;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.op;
    s_axis_tdata  <= {r.now, r.sy, r.sx, r.py, r.px, r.addr};
    do @(posedge clk); while (!s_axis_tready);
    p = route_table_apply(r);
    if (typed) p = fixed;
    hop_replies.insert(hop_replies.size(), p);
  endtask

  // Idle cycles after an item; the valid only drops when a gap follows.
  task automatic sender_gap(input bit no_idle);
    int k;
    int g;
    k = $urandom_range(0, 99);
    g = 0;
    if (!no_idle) begin
      if (k >= 90) g = $urandom_range(8, 40);
      else if (k >= 55) g = $urandom_range(1, 3);
    end
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Register writes only happen with nothing in flight.
  task automatic write_interval(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    hold_ticks = v;
  endtask

  task automatic add_row(input op_t op, input logic [31:0] addr,
                         input logic signed [15:0] px, input logic signed [15:0] py,
                         input logic signed [15:0] sx, input logic signed [15:0] sy,
                         input logic [31:0] now, input bit typed,
                         input status_t st, input logic [31:0] hop, input logic [5:0] cnt);
    script_row_t row;
    row.req.op = op;
    row.req.addr = addr;
    row.req.px = px;
    row.req.py = py;
    row.req.sx = sx;
    row.req.sy = sy;
    row.req.now = now;
    row.typed = typed;
    row.rep.status = st;
    row.rep.hop = hop;
    row.rep.count = cnt;
    script.insert(script.size(), row);
  endtask

  // Coordinates: clustered values make ties and near misses common,
  // the rest cover the full range and its two ends.
  function automatic logic signed [15:0] rand_coord();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 16'($urandom_range(0, 40) - 20);
    if (k < 85) return 16'($urandom);
    return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
  endfunction

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------
  initial begin
    hop_req_t    r;
    hop_reply_t  none;
    logic [31:0] pool[64];
    int          pool_n;
    int          sent;
    int          step;
    int          k;
    logic [31:0] clock_now;
    logic [15:0] ivl;

    none.status = ST_OK;
    none.hop = '0;
    none.count = '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part, run with the interval left by reset.
    // empty table: nobody is closer
    add_row(OP_LOOKUP, 32'd0, 16'sd0, 16'sd0, 16'sd100, 16'sd0, 32'd0,
            1, ST_FAR, 32'd0, 6'd0);
    add_row(OP_PURGE, 32'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'hFFFF_FFFF,
            1, ST_OK, 32'd0, 6'd0);
    add_row(OP_BEACON, 32'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd100,
            1, ST_OK, 32'd0, 6'd1);
    add_row(OP_BEACON, 32'hFFFF_FFFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000,
            32'hFFFF_FFFF, 1, ST_OK, 32'd0, 6'd2);
    add_row(OP_BEACON, 32'd5, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 32'd0,
            1, ST_OK, 32'd0, 6'd3);
    // widest squared distances in both directions
    add_row(OP_LOOKUP, 32'hFFFF_FFFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 32'd0,
            1, ST_OK, 32'd5, 6'd3);
    // neighbor exactly as far as self is not closer
    add_row(OP_LOOKUP, 32'd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'd0,
            1, ST_FAR, 32'd0, 6'd3);
    // address zero is a real next hop
    add_row(OP_LOOKUP, 32'd0, 16'sd0, 16'sd0, 16'sd100, 16'sd0, 32'd0,
            1, ST_OK, 32'd0, 6'd3);
    add_row(OP_BEACON, 32'd9, 16'sd1000, 16'sd1000, 16'sd0, 16'sd0, 32'd300,
            0, ST_OK, 32'd0, 6'd0);
    add_row(OP_BEACON, 32'd7, 16'sd1000, 16'sd1000, 16'sd0, 16'sd0, 32'd300,
            0, ST_OK, 32'd0, 6'd0);
    // equal distance: lower address wins
    add_row(OP_LOOKUP, 32'd0, 16'sd1000, 16'sd1000, 16'sd0, 16'sd0, 32'd300,
            1, ST_OK, 32'd7, 6'd5);
    // refresh moves an existing neighbor
    add_row(OP_BEACON, 32'd7, -16'sd1000, -16'sd1000, 16'sd0, 16'sd0, 32'd400,
            0, ST_OK, 32'd0, 6'd0);
    add_row(OP_LOOKUP, 32'd0, 16'sd1000, 16'sd1000, 16'sd0, 16'sd0, 32'd400,
            0, ST_OK, 32'd0, 6'd0);
    // unused opcode leaves everything alone
    add_row(OP_NOP, 32'hA5A5_A5A5, 16'sd1234, -16'sd77, 16'sd9, 16'sd3, 32'd500,
            1, ST_OK, 32'd0, 6'd5);
    // now below the interval, then at or just past the expiry boundaries
    add_row(OP_PURGE, 32'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd4499,
            0, ST_OK, 32'd0, 6'd0);
    add_row(OP_PURGE, 32'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd4500,
            0, ST_OK, 32'd0, 6'd0);
    add_row(OP_PURGE, 32'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd4600,
            0, ST_OK, 32'd0, 6'd0);
    add_row(OP_PURGE, 32'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd4801,
            0, ST_OK, 32'd0, 6'd0);
    add_row(OP_LOOKUP, 32'd0, -16'sd1000, -16'sd1000, -16'sd1000, -16'sd999, 32'd4801,
            0, ST_OK, 32'd0, 6'd0);

    foreach (script[i]) begin
      send_op(script[i].req, script[i].typed, script[i].rep);
      sender_gap(1'b0);
    end

    // Random phases; each starts from an idle block with a new interval.
    for (int ph = 0; ph < PHASES; ph++) begin
      s_axis_tvalid <= 1'b0;
      while (hop_replies.size() != 0) @(posedge clk);
      case (ph)
        0: ivl = 16'hFFFF;
        1: ivl = 16'd1;
        2: ivl = 16'($urandom_range(2, 65534));
        3: ivl = 16'd50;
        default: ivl = 16'($urandom_range(200, 3000));
      endcase
      write_interval(ivl);
      // pools larger than the table drive it full
      case (ph)
        0: pool_n = 40;
        1: pool_n = 6;
        2: pool_n = 24;
        3: pool_n = 64;
        default: pool_n = 36;
      endcase
      for (int i = 0; i < pool_n; i++) pool[i] = $urandom;
      // one phase starts just below the wrap of the tick counter
      clock_now = (ph == 3) ? 32'hFFFF_FF00 : $urandom;
      step = int'(ivl) / 8 + 2;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        k = $urandom_range(0, 99);
        if ($urandom_range(0, 19) == 0) clock_now -= 32'($urandom_range(0, int'(ivl)));
        else clock_now += 32'($urandom_range(0, step));
        r.addr = pool[$urandom_range(0, pool_n - 1)];
        r.px = rand_coord();
        r.py = rand_coord();
        r.sx = rand_coord();
        r.sy = rand_coord();
        r.now = clock_now;
        if (k < 45) begin
          r.op = OP_BEACON;
        end else if (k < 55) begin
          r.op = OP_PURGE;
        end else if (k < 93) begin
          r.op = OP_LOOKUP;
        end else if (k < 96) begin
          r.op = OP_NOP;
        end else begin
          // stray beacon from an address outside the pool
          r.op = OP_BEACON;
          r.addr = $urandom;
        end
        send_op(r, 1'b0, none);
        if (r.op != OP_NOP) sent++;
        sender_gap(sent >= 40 && sent < 80);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (hop_replies.size() != 0) @(posedge clk);
    repeat (OP_CYCLES) @(posedge clk);
    if (mismatches == 0 && hop_replies.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
